// ----- hw/rtl/r64se_pkg.sv -----
// ----------------------------------------------------------------------------
// r64se_pkg
// Shared types, constants and the alphabet lookup of the radix-64 encoder.
// ----------------------------------------------------------------------------
package r64se_pkg;

   localparam int SYM_W     = 6;
   localparam int CHAR_W    = 7;
   localparam int BYTE_W    = 8;
   localparam int HOLD_W    = 4;
   localparam int CNT_W     = 3;
   localparam int Q_DEPTH   = 2;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
   localparam int ALPHA_LEN = 64;

   // leftover bit counts between bytes
   localparam logic [CNT_W-1:0] HELD_NONE = 3'd0;
   localparam logic [CNT_W-1:0] HELD_TWO  = 3'd2;
   localparam logic [CNT_W-1:0] HELD_FOUR = 3'd4;

   // shuffled alphabet, symbol value 0 first
   localparam logic [7:0] ALPHABET [ALPHA_LEN] = '{
      "w", "y", "A", "C", "E", "G", "I", "K", "M", "O", "Q", "S", "U", "W", "Y", "_",
      "0", "2", "4", "6", "8", "a", "c", "e", "g", "i", "k", "m", "o", "q", "s", "u",
      "x", "B", "F", "J", "N", "R", "V", "Z",
      "1", "5", "9", "d", "h", "l", "p", "t", "z", "H", "P", "X",
      "3", "b", "j", "r", "D", "T", "7",
      "n", "L", "f", "-", "v"
   };

   // one classified request: one or two symbols to send
   typedef struct packed {
      logic [SYM_W-1:0] sym_lo;
      logic [SYM_W-1:0] sym_hi;
      logic             two_chars;
      logic             last;
   } r64se_item_type;

   function automatic logic [CHAR_W-1:0] char_of(input logic [SYM_W-1:0] sym);
      logic [7:0] code;
      code = ALPHABET[sym];
      return code[CHAR_W-1:0];
   endfunction

endpackage

// ----- hw/rtl/r64se_front.sv -----
// ----------------------------------------------------------------------------
// r64se_front
// Packs each request byte above the held bits and splits off 6-bit symbols.
// ----------------------------------------------------------------------------
module r64se_front import r64se_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [BYTE_W-1:0]     data_byte,
   input  logic                  last_byte,
   output r64se_item_type        item
);

   logic [HOLD_W-1:0] holder_ff, holder_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [11:0]       packed_bits;

   always_comb begin
      // bits above the byte stay zero, which gives the flush its zero fill
      packed_bits = ({4'b0, data_byte} << count_ff) | {8'b0, holder_ff};

      item.sym_lo    = packed_bits[5:0];
      item.sym_hi    = packed_bits[11:6];
      item.two_chars = (count_ff == HELD_FOUR) || last_byte;
      item.last      = last_byte;

      holder_in = holder_ff;
      count_in  = count_ff;
      if (push) begin
         if (last_byte || (count_ff == HELD_FOUR)) begin
            holder_in = '0;
            count_in  = HELD_NONE;
         end else begin
            holder_in = packed_bits[9:6];
            count_in  = (count_ff == HELD_NONE) ? HELD_TWO : HELD_FOUR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holder_ff <= '0;
         count_ff  <= HELD_NONE;
      end else begin
         holder_ff <= holder_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hw/rtl/r64se_queue.sv -----
// ----------------------------------------------------------------------------
// r64se_queue
// Two-entry queue between the classifying front and the character back end.
// ----------------------------------------------------------------------------
module r64se_queue import r64se_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  r64se_item_type push_item,
   output logic           full,
   input  logic           pop,
   output r64se_item_type head,
   output logic           empty
);

   r64se_item_type       slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- hw/rtl/r64se_back.sv -----
// ----------------------------------------------------------------------------
// r64se_back
// Sends the queued symbols one character per cycle, while rsp_stall is low, through an output register.
// ----------------------------------------------------------------------------
module r64se_back import r64se_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  r64se_item_type    head,
   input  logic              empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CHAR_W-1:0] rsp_code_char,
   output logic              rsp_last_of_item,
   output logic              rsp_end_of_message
);

   logic              valid_ff, valid_in;
   logic              phase_ff, phase_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              item_end_ff, item_end_in;
   logic              msg_end_ff, msg_end_in;
   logic              load;
   logic              final_char;

   assign load       = !valid_ff || !rsp_stall;
   assign final_char = phase_ff || !head.two_chars;
   assign pop        = load && !empty && final_char;

   always_comb begin
      valid_in    = valid_ff;
      phase_in    = phase_ff;
      char_in     = char_ff;
      item_end_in = item_end_ff;
      msg_end_in  = msg_end_ff;
      if (load) begin
         valid_in    = !empty;
         char_in     = char_of(phase_ff ? head.sym_hi : head.sym_lo);
         item_end_in = final_char;
         msg_end_in  = final_char && head.last;
         if (!empty) begin
            phase_in = !final_char;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      item_end_ff <= item_end_in;
      msg_end_ff  <= msg_end_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_code_char      = char_ff;
   assign rsp_last_of_item   = item_end_ff;
   assign rsp_end_of_message = msg_end_ff;

endmodule

// ----- hw/rtl/radix64_shuffled_encoder.sv -----
// ----------------------------------------------------------------------------
// radix64_shuffled_encoder
// Unpadded radix-64 encoder with a fixed shuffled alphabet, LSB-first packing.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_data_byte, req_last_byte
//   rsp      out        rsp_valid/rsp_stall   rsp_code_char, rsp_last_of_item,
//                                             rsp_end_of_message
//
// Each request gives one or two characters; the output register sends one
// character per cycle while rsp_stall is low. A request is stored in a queue
// slot first, and each of its characters then in the output register.
// A two-entry queue sits between front and back end; until it fills, requests
// keep flowing while a character waits in the output register under rsp_stall.
// Synchronous reset clears the held bits, the queue and the output valid.
// ----------------------------------------------------------------------------
module radix64_shuffled_encoder import r64se_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              req_last_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CHAR_W-1:0] rsp_code_char,
   output logic              rsp_last_of_item,
   output logic              rsp_end_of_message
);

   r64se_item_type front_item;
   r64se_item_type head_item;
   logic           push;
   logic           pop;
   logic           queue_full;
   logic           queue_empty;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   r64se_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .item      (front_item)
   );

   r64se_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (pop),
      .head      (head_item),
      .empty     (queue_empty)
   );

   r64se_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head_item),
      .empty              (queue_empty),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_code_char      (rsp_code_char),
      .rsp_last_of_item   (rsp_last_of_item),
      .rsp_end_of_message (rsp_end_of_message)
   );

endmodule
